// ----- hdl/apt_pkg.sv -----
// shared constants and types for the affine point transform
`timescale 1ns / 1ps
`default_nettype none

package apt_pkg;

   // default word geometry, signed fixed point
   localparam int WORD_BITS_DEF = 32;
   localparam int FRAC_BITS_DEF = 16;

   // item commands
   localparam logic CMD_WRITE     = 1'b0;
   localparam logic CMD_TRANSFORM = 1'b1;

   // matrix layout: row-major 3x3 part, then translation x, y, z
   localparam int AXES        = 3;
   localparam int ENTRY_COUNT = 12;
   localparam int TRANS_BASE  = 9;
   localparam int INDEX_BITS  = 4;

   // per-stage load enables handed to every lane
   typedef struct packed {
      logic s1_en;
      logic s2_en;
      logic s3_en;
   } lane_ctl_type;

endpackage

`default_nettype wire

// ----- hdl/apt_lane.sv -----
// one output column: three products, full-width sum, floor shift and clamp
`timescale 1ns / 1ps
`default_nettype none

module apt_lane #(
   parameter int WORD_BITS = apt_pkg::WORD_BITS_DEF,
   parameter int FRAC_BITS = apt_pkg::FRAC_BITS_DEF
) (
   input  wire                         clock,
   input  wire apt_pkg::lane_ctl_type  ctl,
   input  wire logic signed [WORD_BITS-1:0] point_x,
   input  wire logic signed [WORD_BITS-1:0] point_y,
   input  wire logic signed [WORD_BITS-1:0] point_z,
   input  wire logic signed [WORD_BITS-1:0] weight_x,
   input  wire logic signed [WORD_BITS-1:0] weight_y,
   input  wire logic signed [WORD_BITS-1:0] weight_z,
   input  wire logic signed [WORD_BITS-1:0] trans,
   output logic signed [WORD_BITS-1:0]      result,
   output logic                             clip
);

   localparam int PROD_BITS  = 2 * WORD_BITS;
   localparam int TRANS_BITS = WORD_BITS + FRAC_BITS;
   localparam int SUM_BITS   = ((PROD_BITS > TRANS_BITS) ? PROD_BITS : TRANS_BITS) + 2;
   localparam int HIGH_BITS  = SUM_BITS - WORD_BITS + 1;

   logic signed [PROD_BITS-1:0] prod_x_ff, prod_y_ff, prod_z_ff;
   logic signed [PROD_BITS-1:0] prod_x_in, prod_y_in, prod_z_in;
   logic signed [WORD_BITS-1:0] trans_ff;
   logic signed [SUM_BITS-1:0]  sum_ff, sum_in;
   logic signed [SUM_BITS-1:0]  shifted;
   logic [HIGH_BITS-1:0]        high_bits;
   logic signed [WORD_BITS-1:0] result_ff, result_in;
   logic                        clip_ff, clip_in;

   // stage 1: exact products
   assign prod_x_in = PROD_BITS'(point_x) * PROD_BITS'(weight_x);
   assign prod_y_in = PROD_BITS'(point_y) * PROD_BITS'(weight_y);
   assign prod_z_in = PROD_BITS'(point_z) * PROD_BITS'(weight_z);

   // stage 2: translation lifted to product scale, then one wide sum
   assign sum_in = SUM_BITS'(prod_x_ff) + SUM_BITS'(prod_y_ff) + SUM_BITS'(prod_z_ff)
                 + (SUM_BITS'(trans_ff) <<< FRAC_BITS);

   // stage 3: floor shift and clamp to word range
   assign shifted   = sum_ff >>> FRAC_BITS;
   assign high_bits = shifted[SUM_BITS-1:WORD_BITS-1];

   always_comb begin
      if (high_bits == '0 || high_bits == '1) begin
         result_in = shifted[WORD_BITS-1:0];
         clip_in   = 1'b0;
      end else if (shifted[SUM_BITS-1]) begin
         result_in = {1'b1, {(WORD_BITS-1){1'b0}}};
         clip_in   = 1'b1;
      end else begin
         result_in = {1'b0, {(WORD_BITS-1){1'b1}}};
         clip_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.s1_en) begin
         prod_x_ff <= prod_x_in;
         prod_y_ff <= prod_y_in;
         prod_z_ff <= prod_z_in;
         trans_ff  <= trans;
      end
      if (ctl.s2_en) begin
         sum_ff <= sum_in;
      end
      if (ctl.s3_en) begin
         result_ff <= result_in;
         clip_ff   <= clip_in;
      end
   end

   assign result = result_ff;
   assign clip   = clip_ff;

endmodule

`default_nettype wire

// ----- hdl/apt_merge.sv -----
// output register: gathers the three lanes and folds their clip flags
`timescale 1ns / 1ps
`default_nettype none

module apt_merge #(
   parameter int WORD_BITS = apt_pkg::WORD_BITS_DEF
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              lane_valid,
   input  wire logic signed [WORD_BITS-1:0] lane_x,
   input  wire logic signed [WORD_BITS-1:0] lane_y,
   input  wire logic signed [WORD_BITS-1:0] lane_z,
   input  wire                              clip_x,
   input  wire                              clip_y,
   input  wire                              clip_z,
   output logic                             load,
   output logic                             rsp_valid,
   input  wire                              rsp_stall,
   output logic signed [WORD_BITS-1:0]      rsp_result_x,
   output logic signed [WORD_BITS-1:0]      rsp_result_y,
   output logic signed [WORD_BITS-1:0]      rsp_result_z,
   output logic                             rsp_saturated
);

   logic                        valid_ff, valid_in;
   logic signed [WORD_BITS-1:0] x_ff, y_ff, z_ff;
   logic                        sat_ff;

   // free when empty or when the held result leaves this cycle
   assign load     = !valid_ff || !rsp_stall;
   assign valid_in = load ? lane_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         x_ff   <= lane_x;
         y_ff   <= lane_y;
         z_ff   <= lane_z;
         sat_ff <= clip_x | clip_y | clip_z;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_result_x  = x_ff;
   assign rsp_result_y  = y_ff;
   assign rsp_result_z  = z_ff;
   assign rsp_saturated = sat_ff;

endmodule

`default_nettype wire

// ----- hdl/affine_point_transform.sv -----
// top level of the affine point transform: matrix store, lane pipeline and output merge
`timescale 1ns / 1ps
`default_nettype none

// Affine point transform. The block holds a 4x3 matrix in signed fixed point
// (nine rotation/scale entries, row-major with row = input axis, then the x, y, z
// translation) which resets to identity with zero translation. A write item
// (command 0) stores entry_value at entry_index and yields nothing; indexes
// 12 to 15 are ignored. A transform item (command 1) yields one result, the row
// vector (x, y, z) times the matrix plus the translation, each coordinate summed
// exactly, shifted right by FRAC_BITS rounding toward minus infinity and clamped
// to the word range, with saturated set if any coordinate was clamped. One item
// is taken every clock while req_stall is low; a transform result passes
// through the three lane stages (multiply, sum, clamp) and then the output
// register. Each output column has its own lane with three multipliers, so the
// nine products of a point are all formed in the same cycle. A transform sees
// every write transferred before it. Stall from the result side backs up stage
// by stage, so empty stages keep filling while a result waits.

module affine_point_transform #(
   parameter int WORD_BITS = apt_pkg::WORD_BITS_DEF,
   parameter int FRAC_BITS = apt_pkg::FRAC_BITS_DEF
) (
   input  wire                                 clock,
   input  wire                                 reset,
   // request channel
   input  wire                                 req_valid,
   output logic                                req_stall,
   input  wire                                 req_command,
   input  wire [apt_pkg::INDEX_BITS-1:0]       req_entry_index,
   input  wire logic signed [WORD_BITS-1:0]    req_entry_value,
   input  wire logic signed [WORD_BITS-1:0]    req_point_x,
   input  wire logic signed [WORD_BITS-1:0]    req_point_y,
   input  wire logic signed [WORD_BITS-1:0]    req_point_z,
   // response channel
   output logic                                rsp_valid,
   input  wire                                 rsp_stall,
   output logic signed [WORD_BITS-1:0]         rsp_result_x,
   output logic signed [WORD_BITS-1:0]         rsp_result_y,
   output logic signed [WORD_BITS-1:0]         rsp_result_z,
   output logic                                rsp_saturated
);

   localparam int AXES        = apt_pkg::AXES;
   localparam int ENTRY_COUNT = apt_pkg::ENTRY_COUNT;
   localparam int TRANS_BASE  = apt_pkg::TRANS_BASE;

   // one in the fraction position, the diagonal reset value
   localparam logic [WORD_BITS-1:0] ONE_VALUE = {{(WORD_BITS-1){1'b0}}, 1'b1} << FRAC_BITS;

   logic [WORD_BITS-1:0] matrix_ff [ENTRY_COUNT];

   // valid bits of the three lane stages
   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic s3_valid_ff, s3_valid_in;

   apt_pkg::lane_ctl_type lane_ctl;
   logic                  out_load;
   logic                  req_transfer;
   logic                  is_write;
   logic                  is_transform;

   logic signed [WORD_BITS-1:0] lane_result [AXES];
   logic [AXES-1:0]             lane_clip;

   // each stage moves on when empty or when the one after it moves on
   always_comb begin
      lane_ctl.s3_en = !s3_valid_ff || out_load;
      lane_ctl.s2_en = !s2_valid_ff || lane_ctl.s3_en;
      lane_ctl.s1_en = !s1_valid_ff || lane_ctl.s2_en;
   end

   assign req_stall    = !lane_ctl.s1_en;
   assign req_transfer = req_valid && !req_stall;
   assign is_write     = req_transfer && (req_command == apt_pkg::CMD_WRITE);
   assign is_transform = req_transfer && (req_command == apt_pkg::CMD_TRANSFORM);

   assign s1_valid_in = lane_ctl.s1_en ? is_transform : s1_valid_ff;
   assign s2_valid_in = lane_ctl.s2_en ? s1_valid_ff  : s2_valid_ff;
   assign s3_valid_in = lane_ctl.s3_en ? s2_valid_ff  : s3_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   // matrix store: identity on reset, at most one entry per write transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ENTRY_COUNT; i++) begin
            if (i == 0 || i == 4 || i == 8) begin
               matrix_ff[i] <= ONE_VALUE;
            end else begin
               matrix_ff[i] <= '0;
            end
         end
      end else if (is_write) begin
         for (int i = 0; i < ENTRY_COUNT; i++) begin
            if (req_entry_index == apt_pkg::INDEX_BITS'(i)) begin
               matrix_ff[i] <= req_entry_value;
            end
         end
      end
   end

   // one lane per output column, each reading its own column of the matrix
   for (genvar c = 0; c < AXES; c++) begin : g_lane
      apt_lane #(
         .WORD_BITS (WORD_BITS),
         .FRAC_BITS (FRAC_BITS)
      ) u_lane (
         .clock    (clock),
         .ctl      (lane_ctl),
         .point_x  (req_point_x),
         .point_y  (req_point_y),
         .point_z  (req_point_z),
         .weight_x (matrix_ff[c]),
         .weight_y (matrix_ff[AXES + c]),
         .weight_z (matrix_ff[2 * AXES + c]),
         .trans    (matrix_ff[TRANS_BASE + c]),
         .result   (lane_result[c]),
         .clip     (lane_clip[c])
      );
   end

   // output register and clip fold
   apt_merge #(
      .WORD_BITS (WORD_BITS)
   ) u_merge (
      .clock         (clock),
      .reset         (reset),
      .lane_valid    (s3_valid_ff),
      .lane_x        (lane_result[0]),
      .lane_y        (lane_result[1]),
      .lane_z        (lane_result[2]),
      .clip_x        (lane_clip[0]),
      .clip_y        (lane_clip[1]),
      .clip_z        (lane_clip[2]),
      .load          (out_load),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_result_x  (rsp_result_x),
      .rsp_result_y  (rsp_result_y),
      .rsp_result_z  (rsp_result_z),
      .rsp_saturated (rsp_saturated)
   );

endmodule

`default_nettype wire
